/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the LED dimmer.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define SLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that an implication holds on every rising clock edge outside of reset.
`define SLD_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

/* src/sld_pkg.sv */
// Package for the single-key LED dimmer: types, register indexes, reset values.
// Used by sld_step and single_key_led_dimmer; depends on nothing.
package sld_pkg;

    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned COUNT_W = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LEVEL  = 3'd6;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL      = 8'd8;
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL      = 8'd255;
    localparam logic [COUNT_W-1:0] RST_LONG_PRESS     = 10'd100;
    localparam logic [LEVEL_W-1:0] RST_FAST_THRESHOLD = 8'd150;
    localparam logic [LEVEL_W-1:0] RST_LOAD_THRESHOLD = 8'd70;
    localparam logic [COUNT_W-1:0] RST_RESET_HOLD     = 10'd300;
    localparam logic [LEVEL_W-1:0] RST_INITIAL_LEVEL  = 8'd200;

    // Ramp step periods in ticks
    localparam logic [COUNT_W-1:0] FAST_PERIOD = 10'd2;
    localparam logic [COUNT_W-1:0] SLOW_PERIOD = 10'd5;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_HELD = 2'd2
    } sld_phase_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
        logic [COUNT_W-1:0] long_press_ticks;
        logic [LEVEL_W-1:0] fast_threshold;
        logic [LEVEL_W-1:0] load_threshold;
        logic [COUNT_W-1:0] reset_hold_ticks;
        logic [LEVEL_W-1:0] initial_level;
    } sld_cfg_t;

    typedef struct packed {
        logic               powered;
        sld_phase_t         press_phase;
        logic [COUNT_W-1:0] hold_count;
        logic               ramping;
        logic [LEVEL_W-1:0] level;
        logic               going_down;
        logic               current_sel;
        logic               halted;
    } sld_state_t;

    typedef struct packed {
        logic               lamp_on;
        logic [LEVEL_W-1:0] duty;
        logic               load_on;
        logic               current_high;
        logic               save_request;
        logic               limit_hit;
        logic               factory_reset;
    } sld_result_t;

endpackage

/* src/single_key_led_dimmer.sv */
// Top level of the single-key LED dimmer: config registers, state and result register.
// Depends on sld_pkg, sld_step and assert_macros.svh.
//
//  channel  | ports                               | role
//  ---------+-------------------------------------+-------------------------------
//  s_       | s_valid s_ready s_key_down          | one key sample per tick
//  m_       | m_valid m_ready m_lamp_on .. m_*    | one result item per tick
//  cfg_     | cfg_valid cfg_ready cfg_index/data  | register writes, always ready
//
// One item per cycle sustained while m_ready is high; its result appears in the cycle after acceptance.
// The state update is one combinational pass from the state registers into the
// state and result registers. s_ready drops only while a result waits on m_ready.
// Synchronous active-low reset sets the state to its reset values and loads the register defaults.
`include "assert_macros.svh"

module single_key_led_dimmer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_key_down,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_lamp_on,
    output logic [sld_pkg::LEVEL_W-1:0]    m_duty,
    output logic                           m_load_on,
    output logic                           m_current_high,
    output logic                           m_save_request,
    output logic                           m_limit_hit,
    output logic                           m_factory_reset,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sld_pkg::COUNT_W-1:0]    cfg_data
);
    import sld_pkg::*;

    sld_cfg_t    cfg_reg;
    sld_cfg_t    cfg_next;
    sld_state_t  st_reg;
    sld_state_t  st_next;
    sld_state_t  step_state;
    sld_result_t step_res;
    sld_result_t res_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        in_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~m_valid_reg | m_ready;
    assign in_fire   = s_valid & s_ready;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_LEVEL:      cfg_next.min_level        = cfg_data[LEVEL_W-1:0];
                CFG_MAX_LEVEL:      cfg_next.max_level        = cfg_data[LEVEL_W-1:0];
                CFG_LONG_PRESS:     cfg_next.long_press_ticks = cfg_data;
                CFG_FAST_THRESHOLD: cfg_next.fast_threshold   = cfg_data[LEVEL_W-1:0];
                CFG_LOAD_THRESHOLD: cfg_next.load_threshold   = cfg_data[LEVEL_W-1:0];
                CFG_RESET_HOLD:     cfg_next.reset_hold_ticks = cfg_data;
                CFG_INITIAL_LEVEL:  cfg_next.initial_level    = cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_level        <= RST_MIN_LEVEL;
            cfg_reg.max_level        <= RST_MAX_LEVEL;
            cfg_reg.long_press_ticks <= RST_LONG_PRESS;
            cfg_reg.fast_threshold   <= RST_FAST_THRESHOLD;
            cfg_reg.load_threshold   <= RST_LOAD_THRESHOLD;
            cfg_reg.reset_hold_ticks <= RST_RESET_HOLD;
            cfg_reg.initial_level    <= RST_INITIAL_LEVEL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sld_step u_step (
        .cfg      (cfg_reg),
        .cur      (st_reg),
        .key_down (s_key_down),
        .nxt      (step_state),
        .res      (step_res)
    );

    // Advance the state only on an accepted item
    assign st_next      = in_fire ? step_state : st_reg;
    assign m_valid_next = in_fire | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.powered     <= 1'b1;
            st_reg.press_phase <= PH_IDLE;
            st_reg.hold_count  <= '0;
            st_reg.ramping     <= 1'b0;
            st_reg.level       <= RST_INITIAL_LEVEL;
            st_reg.going_down  <= 1'b0;
            st_reg.current_sel <= 1'b1;
            st_reg.halted      <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= step_res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_lamp_on       = res_reg.lamp_on;
    assign m_duty          = res_reg.duty;
    assign m_load_on       = res_reg.load_on;
    assign m_current_high  = res_reg.current_high;
    assign m_save_request  = res_reg.save_request;
    assign m_limit_hit     = res_reg.limit_hit;
    assign m_factory_reset = res_reg.factory_reset;

    `SLD_ASSERT(a_dark_when_off, (m_valid_reg && !m_lamp_on) |-> (m_duty == '0 && !m_load_on), "duty or load on while lamp off")
    `SLD_ASSERT(a_one_pulse, m_valid_reg |-> $onehot0({m_save_request, m_limit_hit, m_factory_reset}), "more than one pulse in a result")
    `SLD_ASSERT_IMP(a_reset_halts, (in_fire && step_res.factory_reset), (st_reg.halted && m_factory_reset), "factory reset without halt")
    `SLD_ASSERT_IMP(a_halt_sticks, st_reg.halted, st_reg.halted, "halt released without reset")

endmodule

/* src/sld_step.sv */
// One-tick update of the dimmer: key handling, hold counting and ramp step.
// Pure combinational logic; depends on sld_pkg.
module sld_step (
    input  sld_pkg::sld_cfg_t    cfg,
    input  sld_pkg::sld_state_t  cur,
    input  logic                 key_down,
    output sld_pkg::sld_state_t  nxt,
    output sld_pkg::sld_result_t res
);
    import sld_pkg::*;

    logic [COUNT_W-1:0] hold_inc;
    logic [COUNT_W-1:0] period;
    logic               do_step;
    logic               save;
    logic               limit;
    logic               freset;

    // Saturating hold counter and ramp period for this tick
    assign hold_inc = (cur.hold_count == COUNT_MAX) ? COUNT_MAX : cur.hold_count + 1'b1;
    assign period   = (cur.level > cfg.fast_threshold) ? FAST_PERIOD : SLOW_PERIOD;

    // Next state and pulses
    always_comb begin
        nxt     = cur;
        do_step = 1'b0;
        save    = 1'b0;
        limit   = 1'b0;
        freset  = 1'b0;
        if (!cur.halted) begin
            if (cur.powered) begin
                case (cur.press_phase)
                    PH_HELD: begin
                        if (!key_down) begin
                            if (cur.ramping) begin
                                save = 1'b1;
                            end else begin
                                nxt.powered     = 1'b0;
                                nxt.current_sel = 1'b1;
                                if (cur.level < cfg.min_level) begin
                                    nxt.level = cfg.initial_level;
                                end
                            end
                            nxt.press_phase = PH_IDLE;
                            nxt.ramping     = 1'b0;
                            nxt.hold_count  = '0;
                        end else begin
                            nxt.hold_count = hold_inc;
                            if (!cur.ramping) begin
                                if (hold_inc >= cfg.long_press_ticks) begin
                                    nxt.ramping    = 1'b1;
                                    nxt.hold_count = '0;
                                    do_step        = 1'b1;
                                end
                            end else if (hold_inc >= period) begin
                                nxt.hold_count = '0;
                                do_step        = 1'b1;
                            end
                        end
                    end
                    PH_WAIT: begin
                        if (key_down) begin
                            nxt.press_phase = PH_HELD;
                            nxt.hold_count  = '0;
                            nxt.ramping     = 1'b0;
                        end else begin
                            nxt.press_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        nxt.press_phase = key_down ? PH_WAIT : PH_IDLE;
                    end
                endcase

                // One ramp step, reversing at a limit
                if (do_step) begin
                    if (!cur.going_down) begin
                        nxt.current_sel = 1'b1;
                        if (cur.level < cfg.max_level) begin
                            nxt.level = cur.level + 1'b1;
                        end else begin
                            nxt.going_down = 1'b1;
                            limit          = 1'b1;
                        end
                    end else if (cur.level > cfg.min_level) begin
                        nxt.level = cur.level - 1'b1;
                    end else begin
                        nxt.current_sel = 1'b0;
                        nxt.going_down  = 1'b0;
                        limit           = 1'b1;
                    end
                end
            end else begin
                // Lamp off: count the hold, factory reset on a long hold, turn on at release
                if (key_down) begin
                    nxt.press_phase = PH_HELD;
                    if (cur.press_phase != PH_HELD) begin
                        nxt.hold_count = 10'd1;
                    end else begin
                        nxt.hold_count = hold_inc;
                    end
                    if (nxt.hold_count >= cfg.reset_hold_ticks) begin
                        freset     = 1'b1;
                        nxt.halted = 1'b1;
                    end
                end else if (cur.press_phase == PH_HELD) begin
                    nxt.powered     = 1'b1;
                    nxt.press_phase = PH_IDLE;
                    nxt.hold_count  = '0;
                    nxt.ramping     = 1'b0;
                    if (cur.level == cfg.min_level) begin
                        nxt.current_sel = 1'b0;
                    end
                end else begin
                    nxt.press_phase = PH_IDLE;
                end
            end
        end
    end

    // Result fields from the updated state
    always_comb begin
        res.lamp_on       = nxt.powered & ~nxt.halted;
        res.duty          = res.lamp_on ? nxt.level : '0;
        res.load_on       = res.lamp_on & (nxt.level <= cfg.load_threshold);
        res.current_high  = nxt.current_sel;
        res.save_request  = save;
        res.limit_hit     = limit;
        res.factory_reset = freset;
    end

endmodule

/* tb/single_key_led_dimmer_test.sv */
// Self-checking testbench for the single-key LED dimmer: key ticks in, one result per tick out.
// A scoreboard class predicts each result from its own copy of the state and registers.
// Depends on sld_pkg and the single_key_led_dimmer RTL.
module single_key_led_dimmer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sld_pkg::*;

    // Directed key pattern: idle, bounce, long hold ramping into max and reversing,
    // release with save, short press to turn off, idle while off, press and release to turn on
    localparam logic [0:16] PROBE_KEYS = 17'b01011111101100100;
    localparam int unsigned SETTING_TICKS = 240;

    // Predict the dimmer's results and check the ones the block delivers
    class dimmer_tracker;
        logic [LEVEL_W-1:0] min_lv, max_lv, fast_thr, load_thr, init_lv;
        logic [COUNT_W-1:0] long_ticks, off_hold_ticks;
        bit                 powered, ramping, going_down, cur_sel, halted;
        sld_phase_t         phase;
        logic [COUNT_W-1:0] hold;
        logic [LEVEL_W-1:0] level;
        sld_result_t        expected_q[$];
        int                 errors, checked, reversals, saves, turn_offs, resets;

        function new();
            min_lv = RST_MIN_LEVEL;
            max_lv = RST_MAX_LEVEL;
            long_ticks = RST_LONG_PRESS;
            fast_thr = RST_FAST_THRESHOLD;
            load_thr = RST_LOAD_THRESHOLD;
            off_hold_ticks = RST_RESET_HOLD;
            init_lv = RST_INITIAL_LEVEL;
            powered = 1'b1;
            ramping = 1'b0;
            going_down = 1'b0;
            cur_sel = 1'b1;
            halted = 1'b0;
            phase = PH_IDLE;
            hold = '0;
            level = RST_INITIAL_LEVEL;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
            case (idx)
                CFG_MIN_LEVEL:      min_lv = data[LEVEL_W-1:0];
                CFG_MAX_LEVEL:      max_lv = data[LEVEL_W-1:0];
                CFG_LONG_PRESS:     long_ticks = data;
                CFG_FAST_THRESHOLD: fast_thr = data[LEVEL_W-1:0];
                CFG_LOAD_THRESHOLD: load_thr = data[LEVEL_W-1:0];
                CFG_RESET_HOLD:     off_hold_ticks = data;
                CFG_INITIAL_LEVEL:  init_lv = data[LEVEL_W-1:0];
                default: ;
            endcase
        endfunction

        // Move the level one step; report a reversal at a limit
        function bit ramp_once();
            if (!going_down) begin
                cur_sel = 1'b1;
                if (level < max_lv) begin
                    level = level + 1'b1;
                    return 1'b0;
                end
                going_down = 1'b1;
                return 1'b1;
            end
            if (level > min_lv) begin
                level = level - 1'b1;
                return 1'b0;
            end
            cur_sel = 1'b0;
            going_down = 1'b0;
            return 1'b1;
        endfunction

        // Advance the state by one accepted tick and queue the result it causes
        function void note_tick(bit key);
            sld_result_t        res;
            logic [COUNT_W-1:0] period;
            res = '0;
            if (!halted) begin
                if (powered) begin
                    if (phase == PH_HELD) begin
                        if (!key) begin
                            if (ramping) begin
                                res.save_request = 1'b1;
                            end else begin
                                powered = 1'b0;
                                cur_sel = 1'b1;
                                if (level < min_lv) level = init_lv;
                                turn_offs++;
                            end
                            phase = PH_IDLE;
                            ramping = 1'b0;
                            hold = '0;
                        end else begin
                            if (hold != COUNT_MAX) hold = hold + 1'b1;
                            if (!ramping) begin
                                if (hold >= long_ticks) begin
                                    ramping = 1'b1;
                                    hold = '0;
                                    res.limit_hit = ramp_once();
                                end
                            end else begin
                                period = (level > fast_thr) ? FAST_PERIOD : SLOW_PERIOD;
                                if (hold >= period) begin
                                    hold = '0;
                                    res.limit_hit = ramp_once();
                                end
                            end
                        end
                    end else if (phase == PH_WAIT) begin
                        // confirm the press only if still held
                        if (key) begin
                            phase = PH_HELD;
                            hold = '0;
                            ramping = 1'b0;
                        end else begin
                            phase = PH_IDLE;
                        end
                    end else begin
                        phase = key ? PH_WAIT : PH_IDLE;
                    end
                end else begin
                    // lamp off: count the hold, factory reset on a long hold, turn on at release
                    if (key) begin
                        if (phase != PH_HELD) begin
                            phase = PH_HELD;
                            hold = '0;
                        end
                        if (hold != COUNT_MAX) hold = hold + 1'b1;
                        if (hold >= off_hold_ticks) begin
                            res.factory_reset = 1'b1;
                            halted = 1'b1;
                        end
                    end else if (phase == PH_HELD) begin
                        powered = 1'b1;
                        phase = PH_IDLE;
                        hold = '0;
                        ramping = 1'b0;
                        if (level == min_lv) cur_sel = 1'b0;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
            end
            if (powered && !halted) begin
                res.lamp_on = 1'b1;
                res.duty = level;
                res.load_on = (level <= load_thr);
            end
            res.current_high = cur_sel;
            reversals += res.limit_hit;
            saves += res.save_request;
            resets += res.factory_reset;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [LEVEL_W-1:0] want,
                                    logic [LEVEL_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Compare one delivered result with the oldest prediction
        function void check_result(sld_result_t got);
            sld_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no item pending, actual %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("lamp_on", want.lamp_on, got.lamp_on);
            compare_field("duty", want.duty, got.duty);
            compare_field("load_on", want.load_on, got.load_on);
            compare_field("current_high", want.current_high, got.current_high);
            compare_field("save_request", want.save_request, got.save_request);
            compare_field("limit_hit", want.limit_hit, got.limit_hit);
            compare_field("factory_reset", want.factory_reset, got.factory_reset);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_key_down = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_lamp_on;
    logic [LEVEL_W-1:0]   m_duty;
    logic                 m_load_on;
    logic                 m_current_high;
    logic                 m_save_request;
    logic                 m_limit_hit;
    logic                 m_factory_reset;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data = '0;

    dimmer_tracker tracker = new();
    int unsigned   send_idle_pct = 14;
    int unsigned   recv_idle_pct = 46;
    int unsigned   ticks_sent = 0;

    single_key_led_dimmer dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Stall the result channel at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every result taken from the block
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_result({m_lamp_on, m_duty, m_load_on, m_current_high,
                                  m_save_request, m_limit_hit, m_factory_reset});
    end

    // Offer one key tick, idling at random first, and hold it until taken
    task automatic send_key(input bit key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_key_down <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.note_tick(key);
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[COUNT_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, val[COUNT_W-1:0]);
    endtask

    task automatic apply_setting(input int unsigned mn, input int unsigned mx,
                                 input int unsigned lp, input int unsigned ft,
                                 input int unsigned lt, input int unsigned rh,
                                 input int unsigned il);
        write_reg(CFG_MIN_LEVEL, mn);
        write_reg(CFG_MAX_LEVEL, mx);
        write_reg(CFG_LONG_PRESS, lp);
        write_reg(CFG_FAST_THRESHOLD, ft);
        write_reg(CFG_LOAD_THRESHOLD, lt);
        write_reg(CFG_RESET_HOLD, rh);
        write_reg(CFG_INITIAL_LEVEL, il);
        cfg_valid <= 1'b0;
    endtask

    // Hold off the sender until every predicted result has been taken
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.expected_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Receiver idles most first, then sender, then neither
    function void set_idle_mode();
        if (ticks_sent < 550) begin
            send_idle_pct = 14;
            recv_idle_pct = 46;
        end else if (ticks_sent < 1100) begin
            send_idle_pct = 46;
            recv_idle_pct = 14;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    // One key gesture: bounce, short press, long press with ramp, or noise; then release
    task automatic play_gesture();
        int unsigned kind, press, lp;
        lp = tracker.long_ticks;
        kind = $urandom_range(99);
        if (kind >= 90) begin
            repeat ($urandom_range(8, 1)) send_key($urandom_range(1));
        end else begin
            if (kind < 12)
                press = 1;
            else if (kind < 45 || lp > 200)
                press = $urandom_range(2, (lp < 30) ? lp + 1 : 31);
            else
                press = lp + 2 + (($urandom_range(3) == 0) ? $urandom_range(300)
                                                          : $urandom_range(40));
            repeat (press) send_key(1'b1);
        end
        repeat ($urandom_range(6, 1)) send_key(1'b0);
    endtask

    initial begin
        int unsigned start_tick;
        int          guard;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pass with a short long-press time and max just above the level
        apply_setting(8, 201, 2, 150, 255, 1023, 200);
        for (int i = 0; i < 17; i++) send_key(PROBE_KEYS[i]);
        wait_idle();

        // random gestures under several register settings
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: apply_setting(8, 255, 3, 150, 70, 1023, 200);
                1: apply_setting(0, 255, 1, 0, 255, 600, 0);
                2: apply_setting(100, 140, 12, 120, 110, 800, 120);
                3: apply_setting(255, 0, 6, 255, 0, 1023, 255);
                default: apply_setting($urandom_range(255), $urandom_range(255),
                                       $urandom_range(60, 1), $urandom_range(255),
                                       $urandom_range(255), $urandom_range(1023, 600),
                                       $urandom_range(255));
            endcase
            start_tick = ticks_sent;
            while (ticks_sent - start_tick < SETTING_TICKS) begin
                set_idle_mode();
                play_gesture();
            end
            wait_idle();
        end

        // final setting: any hold while off trips the factory reset, then the block halts
        apply_setting(0, 255, 1023, 200, 128, 1, 50);
        guard = 0;
        while (!tracker.halted && guard < 10) begin
            if (tracker.powered) begin
                send_key(1'b1);
                send_key(1'b1);
                send_key(1'b0);
            end else begin
                send_key(1'b1);
            end
            guard++;
        end
        start_tick = ticks_sent;
        while (ticks_sent - start_tick < 80) begin
            set_idle_mode();
            play_gesture();
        end
        wait_idle();

        $display("checked %0d results over %0d key ticks under 7 register settings",
                 tracker.checked, ticks_sent);
        $display("ramp reversals %0d, saves %0d, turn-offs %0d, factory resets %0d",
                 tracker.reversals, tracker.saves, tracker.turn_offs, tracker.resets);
        if (tracker.errors == 0 && tracker.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
